// File: src/pled_pkg.sv
`default_nettype none
package pled_pkg;

   // event kinds
   localparam logic [2:0] KIND_TICK   = 3'd0;
   localparam logic [2:0] KIND_KEYB   = 3'd1;
   localparam logic [2:0] KIND_AUX    = 3'd2;
   localparam logic [2:0] KIND_TOGGLE = 3'd3;
   localparam logic [2:0] KIND_IDLE   = 3'd4;

   // result actions
   localparam logic [2:0] ACT_NONE      = 3'd0;
   localparam logic [2:0] ACT_FWD_KEYB  = 3'd1;
   localparam logic [2:0] ACT_FWD_MOUSE = 3'd2;
   localparam logic [2:0] ACT_SEND_KEYB = 3'd3;
   localparam logic [2:0] ACT_DISCARD   = 3'd4;

   // set-lamps handshake phases
   localparam logic [2:0] PHASE_IDLE      = 3'd0;
   localparam logic [2:0] PHASE_SEND_CMD  = 3'd1;
   localparam logic [2:0] PHASE_AWAIT_ACK1 = 3'd2;
   localparam logic [2:0] PHASE_SEND_BITS = 3'd3;
   localparam logic [2:0] PHASE_AWAIT_ACK2 = 3'd4;

   localparam logic [7:0] ACK_BYTE      = 8'hFA;
   localparam logic [7:0] SET_LAMPS_CMD = 8'hED;
   localparam logic [7:0] TICK_MAX      = 8'hFF;

   // register map
   localparam int          CSR_ADDR_W       = 3;
   localparam logic [CSR_ADDR_W-1:0] CSR_INIT_TIMEOUT = 3'd0;
   localparam logic [7:0]  INIT_TIMEOUT_RESET = 8'd20;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] data;
      logic       aux_flag;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] out_byte;
      logic [2:0] lamp_bits;
   } rsp_type;

endpackage
`default_nettype wire

// File: src/pled_req_if.sv
`default_nettype none
interface pled_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] kind;
   logic [7:0] data;
   logic       aux_flag;

   modport source (output valid, output kind, output data, output aux_flag, input ready);
   modport sink   (input valid, input kind, input data, input aux_flag, output ready);
endinterface
`default_nettype wire

// File: src/pled_rsp_if.sv
`default_nettype none
interface pled_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] action;
   logic [7:0] out_byte;
   logic [2:0] lamp_bits;

   modport source (output valid, output action, output out_byte, output lamp_bits,
                   input ready);
   modport sink   (input valid, input action, input out_byte, input lamp_bits,
                   output ready);
endinterface
`default_nettype wire

// File: src/pled_csr.sv
`default_nettype none
module pled_csr
   import pled_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready,
   output logic      [7:0]            init_timeout
);

   logic [7:0] timeout_ff;
   logic [7:0] timeout_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite && (paddr == CSR_INIT_TIMEOUT);

   always_comb begin
      timeout_in = timeout_ff;
      if (wr_en) begin
         timeout_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= INIT_TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr == CSR_INIT_TIMEOUT) begin
         prdata = {24'd0, timeout_ff};
      end
   end

   assign init_timeout = timeout_ff;

endmodule
`default_nettype wire

// File: src/pled_core.sv
`default_nettype none
module pled_core
   import pled_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic [7:0] init_timeout,
   pled_req_if.sink        req_ch,
   pled_rsp_if.source      rsp_ch
);

   logic       in_vld_ff, in_vld_in;
   req_type    in_ff, in_in;
   logic       out_vld_ff, out_vld_in;
   rsp_type    out_ff, out_in;

   logic [2:0] phase_ff, phase_in;
   logic [2:0] lamps_ff, lamps_in;
   logic       mouse_rdy_ff, mouse_rdy_in;
   logic [7:0] ticks_ff, ticks_in;

   logic       adv;
   logic [7:0] ticks_sat;
   logic [2:0] action;
   logic [7:0] byte_val;

   // stage moves when the result slot is free or being drained
   assign adv          = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || adv;

   always_comb begin
      in_vld_in = in_vld_ff;
      in_in     = in_ff;
      if (req_ch.ready) begin
         in_vld_in = req_ch.valid;
         in_in     = '{kind: req_ch.kind, data: req_ch.data, aux_flag: req_ch.aux_flag};
      end
   end

   assign ticks_sat = (ticks_ff == TICK_MAX) ? ticks_ff : ticks_ff + 8'd1;

   always_comb begin
      phase_in     = phase_ff;
      lamps_in     = lamps_ff;
      mouse_rdy_in = mouse_rdy_ff;
      ticks_in     = ticks_ff;
      action       = ACT_NONE;
      byte_val     = '0;
      unique case (in_ff.kind)
         KIND_TICK: begin
            if (!mouse_rdy_ff) begin
               ticks_in = ticks_sat;
               if (ticks_sat >= init_timeout) begin
                  mouse_rdy_in = 1'b1;
                  action       = ACT_DISCARD;
               end
            end
         end
         KIND_KEYB: begin
            if (in_ff.data == ACK_BYTE && phase_ff == PHASE_AWAIT_ACK1) begin
               phase_in = PHASE_SEND_BITS;
            end else if (in_ff.data == ACK_BYTE && phase_ff == PHASE_AWAIT_ACK2) begin
               phase_in = PHASE_IDLE;
            end else begin
               action   = ACT_FWD_KEYB;
               byte_val = in_ff.data;
            end
         end
         KIND_AUX: begin
            if (in_ff.aux_flag) begin
               if (!mouse_rdy_ff) begin
                  mouse_rdy_in = 1'b1;    // first mouse byte is dropped
               end else begin
                  action   = ACT_FWD_MOUSE;
                  byte_val = in_ff.data;
               end
            end
         end
         KIND_TOGGLE: begin
            if (in_ff.data[7:2] == 6'd0 && in_ff.data[1:0] != 2'd3) begin
               lamps_in = lamps_ff ^ 3'(3'b001 << in_ff.data[1:0]);
               if (phase_ff == PHASE_IDLE) begin
                  phase_in = PHASE_SEND_CMD;
               end
            end
         end
         KIND_IDLE: begin
            if (phase_ff == PHASE_SEND_CMD) begin
               action   = ACT_SEND_KEYB;
               byte_val = SET_LAMPS_CMD;
               phase_in = PHASE_AWAIT_ACK1;
            end else if (phase_ff == PHASE_SEND_BITS) begin
               action   = ACT_SEND_KEYB;
               byte_val = {5'd0, lamps_ff};
               phase_in = PHASE_AWAIT_ACK2;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      out_vld_in = out_vld_ff && !rsp_ch.ready;
      out_in     = out_ff;
      if (adv) begin
         out_vld_in = 1'b1;
         out_in     = '{action: action, out_byte: byte_val, lamp_bits: lamps_in};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff    <= 1'b0;
         out_vld_ff   <= 1'b0;
         phase_ff     <= PHASE_IDLE;
         lamps_ff     <= '0;
         mouse_rdy_ff <= 1'b0;
         ticks_ff     <= '0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (adv) begin
            phase_ff     <= phase_in;
            lamps_ff     <= lamps_in;
            mouse_rdy_ff <= mouse_rdy_in;
            ticks_ff     <= ticks_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      in_ff  <= in_in;
      out_ff <= out_in;
   end

   assign rsp_ch.valid     = out_vld_ff;
   assign rsp_ch.action    = out_ff.action;
   assign rsp_ch.out_byte  = out_ff.out_byte;
   assign rsp_ch.lamp_bits = out_ff.lamp_bits;

   a_phase_range: assert property (@(posedge clock) disable iff (reset)
      phase_ff <= PHASE_AWAIT_ACK2)
      else $error("handshake phase out of range");

   a_mouse_sticky: assert property (@(posedge clock) disable iff (reset)
      mouse_rdy_ff |=> mouse_rdy_ff)
      else $error("mouse ready flag cleared");

   a_no_byte_on_none: assert property (@(posedge clock) disable iff (reset)
      out_vld_ff && (out_ff.action == ACT_NONE || out_ff.action == ACT_DISCARD)
      |-> out_ff.out_byte == 8'd0)
      else $error("byte present on action without byte");

   a_send_sets_wait: assert property (@(posedge clock) disable iff (reset)
      adv && action == ACT_SEND_KEYB
      |=> phase_ff == PHASE_AWAIT_ACK1 || phase_ff == PHASE_AWAIT_ACK2)
      else $error("send did not move handshake to an ack wait");

endmodule
`default_nettype wire

// File: src/ps2_led_handshake_event_router.sv
`default_nettype none
// PS/2 set-lamps handshake and event router. One controller event enters per
// request on req_ch (tick, keyboard byte, aux byte, lamp toggle, idle slot) and
// yields exactly one result on rsp_ch: an action, the byte it carries and the
// lamp bits after the event. Each request passes an input register, combinational
// decode and state update, and a result register, and a new request is taken every
// cycle while the result side keeps up. The
// handshake sends 0xED, then the lamp bits, only in idle slots; the matching
// 0xFA acks are swallowed. The APB register at byte address 0 holds the mouse
// init timeout in ticks (reset 20); write it only while no request is in flight.
module ps2_led_handshake_event_router
   import pled_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   pled_req_if.sink                   req_ch,
   pled_rsp_if.source                 rsp_ch,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [31:0]           pwdata,
   output logic      [31:0]           prdata,
   output logic                       pready
);

   logic [7:0] init_timeout;

   pled_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .prdata       (prdata),
      .pready       (pready),
      .init_timeout (init_timeout)
   );

   pled_core u_core (
      .clock        (clock),
      .reset        (reset),
      .init_timeout (init_timeout),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch)
   );

endmodule
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
   import pled_pkg::*;

   localparam logic [7:0] LAMP_SCROLL = 8'd0;
   localparam logic [7:0] LAMP_NUM    = 8'd1;
   localparam logic [7:0] LAMP_CAPS   = 8'd2;
   localparam logic [CSR_ADDR_W-1:0] CSR_UNUSED_ADDR = 3'd4;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_ITEMS    = 222;
   localparam int MAX_PRINTED    = 40;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [31:0]           pwdata;
   logic [31:0]           prdata;
   logic                  pready;

   pled_req_if req_bus();
   pled_rsp_if rsp_bus();

   ps2_led_handshake_event_router u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // router state as predicted
   logic [7:0] timeout_ticks;
   logic [2:0] phase;
   logic [2:0] lamps;
   logic       mouse_up;
   logic [7:0] tick_total;

   rsp_type pending_results[$];
   int      error_count = 0;
   int      items_sent  = 0;
   int      stall_left  = 0;
   int      idle_cycles = 0;
   bit      back_to_back = 1'b0;

   function automatic rsp_type route_event(input req_type ev);
      rsp_type r;
      r.action   = ACT_NONE;
      r.out_byte = 8'h00;
      case (ev.kind)
         KIND_TICK: begin
            if (!mouse_up) begin
               if (tick_total != TICK_MAX) tick_total = tick_total + 8'd1;
               if (tick_total >= timeout_ticks) begin
                  mouse_up = 1'b1;
                  r.action = ACT_DISCARD;
               end
            end
         end
         KIND_KEYB: begin
            if (ev.data == ACK_BYTE && phase == PHASE_AWAIT_ACK1) begin
               phase = PHASE_SEND_BITS;
            end else if (ev.data == ACK_BYTE && phase == PHASE_AWAIT_ACK2) begin
               phase = PHASE_IDLE;
            end else begin
               r.action   = ACT_FWD_KEYB;
               r.out_byte = ev.data;
            end
         end
         KIND_AUX: begin
            if (ev.aux_flag) begin
               if (!mouse_up) begin
                  mouse_up = 1'b1;
               end else begin
                  r.action   = ACT_FWD_MOUSE;
                  r.out_byte = ev.data;
               end
            end
         end
         KIND_TOGGLE: begin
            if (ev.data <= LAMP_CAPS) begin
               lamps = lamps ^ (3'b001 << ev.data[1:0]);
               if (phase == PHASE_IDLE) phase = PHASE_SEND_CMD;
            end
         end
         KIND_IDLE: begin
            if (phase == PHASE_SEND_CMD) begin
               r.action   = ACT_SEND_KEYB;
               r.out_byte = SET_LAMPS_CMD;
               phase      = PHASE_AWAIT_ACK1;
            end else if (phase == PHASE_SEND_BITS) begin
               r.action   = ACT_SEND_KEYB;
               r.out_byte = {5'b00000, lamps};
               phase      = PHASE_AWAIT_ACK2;
            end
         end
         default: ;
      endcase
      r.lamp_bits = lamps;
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= MAX_PRINTED) $display("%0t mismatch: %s", $time, what);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (back_to_back) return 0;
      if (r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // accepted requests feed the predictor; accepted results are checked
   always @(posedge clock) begin : scoreboard
      req_type ev;
      rsp_type want;
      if (!reset && req_bus.valid && req_bus.ready) begin
         ev.kind     = req_bus.kind;
         ev.data     = req_bus.data;
         ev.aux_flag = req_bus.aux_flag;
         pending_results.push_back(route_event(ev));
      end
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            report_mismatch($sformatf("result with no request pending: action %0d byte %02h",
                                      rsp_bus.action, rsp_bus.out_byte));
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.action !== want.action)
               report_mismatch($sformatf("action %0d, expected %0d",
                                         rsp_bus.action, want.action));
            if (rsp_bus.out_byte !== want.out_byte)
               report_mismatch($sformatf("out_byte %02h, expected %02h",
                                         rsp_bus.out_byte, want.out_byte));
            if (rsp_bus.lamp_bits !== want.lamp_bits)
               report_mismatch($sformatf("lamp_bits %0d, expected %0d",
                                         rsp_bus.lamp_bits, want.lamp_bits));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (psel && penable && pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_bus.ready = 1'b0;
         stall_left--;
      end else begin
         rsp_bus.ready = 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // valid stays high across back-to-back requests
   task automatic send_event(input req_type ev);
      int gap;
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid    = 1'b1;
      req_bus.kind     = ev.kind;
      req_bus.data     = ev.data;
      req_bus.aux_flag = ev.aux_flag;
      do @(posedge clock); while (!req_bus.ready);
      items_sent++;
   endtask

   task automatic send_fields(input logic [2:0] kind, input logic [7:0] data,
                              input logic aux_flag);
      req_type ev;
      ev.kind     = kind;
      ev.data     = data;
      ev.aux_flag = aux_flag;
      send_event(ev);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] value);
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b1;
      paddr   = addr;
      pwdata  = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (addr == CSR_INIT_TIMEOUT) timeout_ticks = value[7:0];
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
   endtask

   task automatic csr_check_timeout();
      @(negedge clock);
      psel    = 1'b1;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = CSR_INIT_TIMEOUT;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[7:0] !== timeout_ticks)
         report_mismatch($sformatf("init_timeout_ticks reads %0d, expected %0d",
                                   prdata[7:0], timeout_ticks));
      @(negedge clock);
      psel    = 1'b0;
      penable = 1'b0;
   endtask

   function automatic req_type random_event();
      req_type ev;
      int      pick;
      pick        = $urandom_range(0, 99);
      ev.data     = 8'($urandom);
      ev.aux_flag = 1'($urandom);
      ev.kind     = KIND_IDLE;
      if (pick < 12) begin
         ev.kind = KIND_TICK;
      end else if (pick < 36) begin
         ev.kind = KIND_KEYB;
         if ($urandom_range(0, 1) == 0) ev.data = ACK_BYTE;
      end else if (pick < 54) begin
         ev.kind = KIND_AUX;
         if ($urandom_range(0, 3) != 0) ev.aux_flag = 1'b1;
      end else if (pick < 70) begin
         ev.kind = KIND_TOGGLE;
         if ($urandom_range(0, 4) != 0) ev.data = 8'($urandom_range(0, 2));
      end else if (pick >= 94) begin
         ev.kind = 3'($urandom_range(5, 7));
      end
      return ev;
   endfunction

   // one set-lamps exchange; random requests slip in, steps are sometimes dropped
   task automatic lamp_update();
      req_type steps[5];
      steps[0] = '{kind: KIND_TOGGLE, data: 8'($urandom_range(0, 2)),
                   aux_flag: 1'($urandom)};
      steps[1] = '{kind: KIND_IDLE, data: 8'($urandom), aux_flag: 1'($urandom)};
      steps[2] = '{kind: KIND_KEYB, data: ACK_BYTE, aux_flag: 1'($urandom)};
      steps[3] = '{kind: KIND_IDLE, data: 8'($urandom), aux_flag: 1'($urandom)};
      steps[4] = '{kind: KIND_KEYB, data: ACK_BYTE, aux_flag: 1'($urandom)};
      foreach (steps[i]) begin
         if ($urandom_range(0, 4) == 0) send_event(random_event());
         if ($urandom_range(0, 19) != 0) send_event(steps[i]);
      end
   endtask

   task automatic test_csr_access();
      csr_check_timeout();
      csr_write(CSR_UNUSED_ADDR, $urandom);
      csr_check_timeout();
      csr_write(CSR_INIT_TIMEOUT, 32'd1);
      csr_check_timeout();
      csr_write(CSR_INIT_TIMEOUT, 32'd255);
      csr_check_timeout();
   endtask

   task automatic test_keyboard_lamps();
      send_fields(KIND_KEYB, 8'h00, 1'b0);
      send_fields(KIND_KEYB, 8'hFF, 1'b1);
      send_fields(KIND_KEYB, ACK_BYTE, 1'b0);       // ACK with no handshake running
      send_fields(KIND_TOGGLE, LAMP_NUM, 1'b0);
      send_fields(KIND_TOGGLE, 8'd3, 1'b0);
      send_fields(KIND_TOGGLE, 8'hFF, 1'b1);
      send_fields(KIND_KEYB, ACK_BYTE, 1'b0);       // command not sent yet
      send_fields(KIND_IDLE, 8'h00, 1'b0);
      send_fields(KIND_TOGGLE, LAMP_CAPS, 1'b0);    // mid-handshake toggle
      send_fields(KIND_KEYB, ACK_BYTE, 1'b0);
      send_fields(KIND_IDLE, 8'hFF, 1'b1);
      send_fields(KIND_IDLE, 8'h00, 1'b0);
      send_fields(KIND_KEYB, ACK_BYTE, 1'b1);
      send_fields(KIND_IDLE, 8'h00, 1'b0);
      send_fields(KIND_TOGGLE, LAMP_SCROLL, 1'b0);
   endtask

   task automatic test_mouse_init();
      send_fields(KIND_AUX, 8'h5A, 1'b0);
      repeat (3) send_fields(KIND_TICK, 8'($urandom), 1'($urandom));
      // init ends only once per run: by first mouse byte or by timeout
      if ($urandom_range(0, 1) == 0) begin
         send_fields(KIND_AUX, 8'hA5, 1'b1);
      end else begin
         drain_results();
         csr_write(CSR_INIT_TIMEOUT, 32'd2);    // below the count already reached
         csr_check_timeout();
         send_fields(KIND_TICK, 8'h00, 1'b0);
      end
      send_fields(KIND_TICK, 8'hFF, 1'b1);
      send_fields(KIND_AUX, 8'h00, 1'b1);
      send_fields(KIND_AUX, 8'hFF, 1'b1);
      for (int k = 5; k <= 7; k++) send_fields(3'(k), 8'($urandom), 1'($urandom));
   endtask

   task automatic test_random_traffic();
      logic [31:0] setting;
      int          stop_at;
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_results();
         case (p)
            0:       setting = 32'd1;
            1:       setting = 32'd255;
            3:       setting = 32'(INIT_TIMEOUT_RESET);
            default: setting = 32'($urandom_range(1, 255));
         endcase
         csr_write(CSR_INIT_TIMEOUT, setting);
         csr_check_timeout();
         back_to_back = ($urandom_range(0, 2) == 0);
         stop_at = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) begin
            if ($urandom_range(0, 1) == 0) lamp_update();
            else send_event(random_event());
         end
      end
      back_to_back = 1'b0;
   endtask

   initial begin
      reset            = 1'b1;
      psel             = 1'b0;
      penable          = 1'b0;
      pwrite           = 1'b0;
      paddr            = '0;
      pwdata           = '0;
      req_bus.valid    = 1'b0;
      req_bus.kind     = KIND_IDLE;
      req_bus.data     = 8'h00;
      req_bus.aux_flag = 1'b0;
      rsp_bus.ready    = 1'b0;
      timeout_ticks    = INIT_TIMEOUT_RESET;
      phase            = PHASE_IDLE;
      lamps            = 3'b000;
      mouse_up         = 1'b0;
      tick_total       = 8'h00;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_csr_access();
      test_keyboard_lamps();
      test_mouse_init();
      test_random_traffic();
      drain_results();

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: ps2_led_handshake_event_router.f
src/pled_pkg.sv
src/pled_req_if.sv
src/pled_rsp_if.sv
src/pled_csr.sv
src/pled_core.sv
src/ps2_led_handshake_event_router.sv
dv/tb.sv
